>>> sv/psbb_pkg.sv
// Shared constants and types for the point-set bounds and bandwidth block.
// Used by psbb_alu and point_set_bounds_and_bandwidth; no dependencies.
`default_nettype none

package psbb_pkg;

    // Default parameter values
    localparam int MAX_POINTS_DEF  = 65536;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    // Fixed field widths
    localparam int FIELD_W = 24;
    localparam int CELLS_W = 13;
    localparam int GAMMA_W = 32;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 3;

    // Arithmetic unit widths
    localparam int ALU_AW = 128;
    localparam int ALU_BW = 64;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CELLS_X   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CELLS_Y   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CELLS_T   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BW_SCALE  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SP_RATIO  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_TM_RATIO  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    // Arithmetic unit operations
    typedef logic [1:0] t_op;
    localparam t_op OP_MUL  = 2'd0;
    localparam t_op OP_DIV  = 2'd1;
    localparam t_op OP_SQRT = 2'd2;

    typedef struct packed {
        logic go;
        t_op  op;
    } t_alu_ctl;

endpackage

`default_nettype wire

>>> sv/psbb_alu.sv
// Iterative arithmetic unit: shift-add multiply, restoring divide, integer root.
// One step per cycle; depends on psbb_pkg.
`default_nettype none

module psbb_alu (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire psbb_pkg::t_alu_ctl          i_ctl,
    input  wire logic [psbb_pkg::ALU_AW-1:0] i_a,
    input  wire logic [psbb_pkg::ALU_BW-1:0] i_b,
    output logic                             o_done,
    output logic [psbb_pkg::ALU_AW-1:0]      o_res
);
    import psbb_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_op               r_op;
    logic [ALU_AW-1:0] r_acc;
    logic [ALU_AW-1:0] r_x;
    logic [ALU_BW-1:0] r_y;
    logic [ALU_BW-1:0] r_rem;
    logic [6:0]        r_cnt;

    // Divide step: shift in the next dividend bit, compare and subtract
    logic [ALU_BW-1:0] w_remn;
    logic              w_qbit;
    logic [ALU_BW-1:0] w_rem;
    assign w_remn = {r_rem[ALU_BW-2:0], r_x[ALU_AW-1]};
    assign w_qbit = r_rem[ALU_BW-1] | (w_remn >= r_y);
    assign w_rem  = w_qbit ? (w_remn - r_y) : w_remn;

    // Root step: value in r_x, partial root in r_acc, trial bit in r_y
    logic [ALU_BW-1:0] w_trial;
    logic              w_ge;
    assign w_trial = r_acc[ALU_BW-1:0] + r_y;
    assign w_ge    = r_x[ALU_BW-1:0] >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.go) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_acc  <= '0;
                r_x    <= i_a;
                r_rem  <= '0;
                case (i_ctl.op)
                    OP_DIV: begin
                        r_y   <= i_b;
                        r_cnt <= 7'd127;
                    end
                    OP_SQRT: begin
                        r_y   <= ALU_BW'(1) << (ALU_BW - 2);
                        r_cnt <= 7'd31;
                    end
                    default: begin
                        r_y   <= i_b;
                        r_cnt <= '0;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_DIV: begin
                        r_x   <= r_x << 1;
                        r_rem <= w_rem;
                        r_acc <= {r_acc[ALU_AW-2:0], w_qbit};
                        r_cnt <= r_cnt - 7'd1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    OP_SQRT: begin
                        r_x   <= w_ge ? ALU_AW'(r_x[ALU_BW-1:0] - w_trial) : r_x;
                        r_acc <= w_ge ? ALU_AW'((r_acc[ALU_BW-1:0] >> 1) + r_y)
                                      : ALU_AW'(r_acc[ALU_BW-1:0] >> 1);
                        r_y   <= r_y >> 2;
                        r_cnt <= r_cnt - 7'd1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: begin
                        // multiply: stops once the multiplier runs out of ones
                        if (r_y == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            if (r_y[0]) r_acc <= r_acc + r_x;
                            r_x <= r_x << 1;
                            r_y <= r_y >> 1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

`default_nettype wire

>>> sv/point_set_bounds_and_bandwidth.sv
// Point-set bounds and Scott's-rule kernel bandwidth, top level.
// Depends on psbb_pkg and psbb_alu.
//
// Usage:
//  Points enter on i_pos_x/y/t with i_last_point; a point transfers on a rising
//  edge with i_start high and o_busy low. Each point keeps o_busy high while
//  one shared 24x24 multiplier squares the three axes in turn, so a new point
//  is taken only after the last one is squared. A point with i_last_point set
//  starts the closing sequence on the shared iterative unit (shift-add multiply,
//  128-step divide, 32-step root): three step divides, variances, two roots,
//  two 20-bit root searches and two gamma divides. A set of fewer than two
//  points only runs the step divides; otherwise the root searches take most of
//  the time. Then o_valid pulses for one cycle with the result on the o_ ports
//  and the accumulated state is cleared. The receiver cannot stall.
//  Configuration writes use i_cfg_valid/o_cfg_ready (always ready) with
//  i_cfg_index and i_cfg_data; write them only while the block is idle.
//  Reset (synchronous, i_rst_n low) restores the register defaults and clears
//  the point state; there is no clearing pass.
`default_nettype none

module point_set_bounds_and_bandwidth #(
    parameter int MAX_POINTS  = psbb_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = psbb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psbb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic signed [psbb_pkg::FIELD_W-1:0] i_pos_x,
    input  wire logic signed [psbb_pkg::FIELD_W-1:0] i_pos_y,
    input  wire logic signed [psbb_pkg::FIELD_W-1:0] i_pos_t,
    input  wire logic                                i_last_point,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [psbb_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire logic [psbb_pkg::FIELD_W-1:0]        i_cfg_data,
    output logic                                     o_valid,
    output logic signed [psbb_pkg::FIELD_W-1:0]      o_x_low,
    output logic signed [psbb_pkg::FIELD_W-1:0]      o_x_high,
    output logic signed [psbb_pkg::FIELD_W-1:0]      o_y_low,
    output logic signed [psbb_pkg::FIELD_W-1:0]      o_y_high,
    output logic signed [psbb_pkg::FIELD_W-1:0]      o_t_low,
    output logic signed [psbb_pkg::FIELD_W-1:0]      o_t_high,
    output logic [psbb_pkg::FIELD_W-1:0]             o_step_x,
    output logic [psbb_pkg::FIELD_W-1:0]             o_step_y,
    output logic [psbb_pkg::FIELD_W-1:0]             o_step_t,
    output logic [psbb_pkg::GAMMA_W-1:0]             o_gamma_space,
    output logic [psbb_pkg::GAMMA_W-1:0]             o_gamma_time,
    output logic [psbb_pkg::STAT_W-1:0]              o_status
);
    import psbb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SH     = FIELD_W - COORD_WIDTH;
    localparam int SUM_W  = 40;
    localparam int SQ_W   = 63;
    localparam int ROOT_W = 20;
    localparam int QS     = FRAC_BITS + 8;
    localparam logic signed [FIELD_W-1:0] COORD_TOP = FIELD_W'((1 << (COORD_WIDTH - 1)) - 1);
    localparam logic signed [FIELD_W-1:0] COORD_BOT = ~COORD_TOP;
    localparam logic [GAMMA_W-1:0] GAMMA_SAT = '1;

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQ   = 5'd1;
    localparam logic [4:0] S_STEP = 5'd2;
    localparam logic [4:0] S_NN   = 5'd3;
    localparam logic [4:0] S_VA   = 5'd4;
    localparam logic [4:0] S_VB   = 5'd5;
    localparam logic [4:0] S_VD   = 5'd6;
    localparam logic [4:0] S_SQS  = 5'd7;
    localparam logic [4:0] S_SQT  = 5'd8;
    localparam logic [4:0] S_RC2  = 5'd9;
    localparam logic [4:0] S_RC3  = 5'd10;
    localparam logic [4:0] S_RP   = 5'd11;
    localparam logic [4:0] S_GD   = 5'd12;
    localparam logic [4:0] S_GN   = 5'd13;
    localparam logic [4:0] S_GQ   = 5'd14;
    localparam logic [4:0] S_OUT  = 5'd15;

    // Configuration
    logic [CELLS_W-1:0] r_cells [3];
    logic [FIELD_W-1:0] r_bw_scale;
    logic [FIELD_W-1:0] r_sp_ratio;
    logic [FIELD_W-1:0] r_tm_ratio;

    // Point state
    logic [CNT_W-1:0]          r_cnt;
    logic signed [FIELD_W-1:0] r_min [3];
    logic signed [FIELD_W-1:0] r_max [3];
    logic signed [SUM_W-1:0]   r_sum [3];
    logic [SQ_W-1:0]           r_sq  [3];
    logic signed [FIELD_W-1:0] r_pt  [3];
    logic                      r_last;
    logic                      r_take;

    // Sequencer and closing-sequence registers
    logic [4:0]         r_state;
    logic               r_wait;
    logic [1:0]         r_ax;
    logic [FIELD_W-1:0] r_step [3];
    logic [ALU_BW-1:0]  r_nn;
    logic [ALU_AW-1:0]  r_ta;
    logic [ALU_BW-1:0]  r_var [3];
    logic [GAMMA_W-1:0] r_sds;
    logic [GAMMA_W-1:0] r_sdt;
    logic [ROOT_W-1:0]  r_res;
    logic [4:0]         r_bit;
    logic               r_rsel;
    logic [ALU_BW-1:0]  r_c2;
    logic [ALU_BW-1:0]  r_c3;
    logic [ROOT_W-1:0]  r_r6;
    logic [ROOT_W-1:0]  r_r5;
    logic               r_gsel;
    logic [ALU_BW-1:0]  r_den;
    logic [ALU_BW-1:0]  r_num;
    logic [GAMMA_W-1:0] r_gs;
    logic [GAMMA_W-1:0] r_gt;
    logic               r_zero;

    // Output registers
    logic                      r_valid;
    logic signed [FIELD_W-1:0] r_o_lo [3];
    logic signed [FIELD_W-1:0] r_o_hi [3];
    logic [FIELD_W-1:0]        r_o_step [3];
    logic [GAMMA_W-1:0]        r_o_gs;
    logic [GAMMA_W-1:0]        r_o_gt;
    logic [STAT_W-1:0]         r_o_stat;

    // Coordinates sign-extended from their low COORD_WIDTH bits
    logic signed [FIELD_W-1:0] w_p [3];
    assign w_p[0] = $signed(i_pos_x << SH) >>> SH;
    assign w_p[1] = $signed(i_pos_y << SH) >>> SH;
    assign w_p[2] = $signed(i_pos_t << SH) >>> SH;

    // Shared squaring multiplier
    logic signed [2*FIELD_W-1:0] w_sq;
    assign w_sq = r_pt[r_ax] * r_pt[r_ax];

    // Per-axis range and effective cell count
    logic signed [FIELD_W:0] w_diff;
    logic [FIELD_W-1:0]      w_range;
    logic [CELLS_W-1:0]      w_cells;
    assign w_diff  = (FIELD_W+1)'(r_max[r_ax]) - (FIELD_W+1)'(r_min[r_ax]);
    assign w_range = w_diff[FIELD_W] ? '0 : w_diff[FIELD_W-1:0];
    assign w_cells = (r_cells[r_ax] == '0) ? CELLS_W'(1) : r_cells[r_ax];

    // Magnitude of the coordinate sum
    logic [SUM_W-1:0] w_mag;
    assign w_mag = r_sum[r_ax][SUM_W-1] ? SUM_W'(-r_sum[r_ax]) : SUM_W'(r_sum[r_ax]);

    logic [ALU_BW-1:0] w_n;
    logic [ALU_BW-1:0] w_sqs_in;
    logic [ALU_BW-1:0] w_sqt_in;
    logic [ROOT_W-1:0] w_cand;
    logic [ALU_AW-1:0] w_target;
    assign w_n      = ALU_BW'(r_cnt);
    assign w_sqs_in = (r_var[0] + r_var[1]) << 16;
    assign w_sqt_in = r_var[2] << 16;
    assign w_cand   = r_res | (ROOT_W'(1) << r_bit);
    assign w_target = r_rsel ? (ALU_AW'(r_cnt) << 80) : (ALU_AW'(r_cnt) << 96);

    // Arithmetic unit
    t_alu_ctl          w_ctl;
    logic [ALU_AW-1:0] w_a;
    logic [ALU_BW-1:0] w_b;
    logic              w_done;
    logic [ALU_AW-1:0] w_res;
    logic              w_alu_st;

    assign w_alu_st = (r_state != S_IDLE) && (r_state != S_SQ) && (r_state != S_OUT);

    // Operand selection per step
    always_comb begin
        w_ctl.go = w_alu_st && !r_wait;
        w_ctl.op = OP_MUL;
        w_a      = '0;
        w_b      = '0;
        case (r_state)
            S_STEP: begin
                w_ctl.op = OP_DIV;
                w_a      = ALU_AW'(w_range);
                w_b      = ALU_BW'(w_cells);
            end
            S_NN: begin
                w_a = ALU_AW'(w_n);
                w_b = w_n - ALU_BW'(1);
            end
            S_VA: begin
                w_a = ALU_AW'(r_sq[r_ax]);
                w_b = w_n;
            end
            S_VB: begin
                w_a = ALU_AW'(w_mag);
                w_b = ALU_BW'(w_mag);
            end
            S_VD: begin
                w_ctl.op = OP_DIV;
                w_a      = r_ta;
                w_b      = r_nn;
            end
            S_SQS: begin
                w_ctl.op = OP_SQRT;
                w_a      = ALU_AW'(w_sqs_in);
            end
            S_SQT: begin
                w_ctl.op = OP_SQRT;
                w_a      = ALU_AW'(w_sqt_in);
            end
            S_RC2: begin
                w_a = ALU_AW'(w_cand);
                w_b = ALU_BW'(w_cand);
            end
            S_RC3: begin
                w_a = ALU_AW'(r_c2);
                w_b = ALU_BW'(w_cand);
            end
            S_RP: begin
                w_a = ALU_AW'(r_c3);
                w_b = r_rsel ? r_c2 : r_c3;
            end
            S_GD: begin
                w_a = ALU_AW'(r_gsel ? r_sdt : r_sds);
                w_b = ALU_BW'(r_bw_scale);
            end
            S_GN: begin
                w_a = ALU_AW'(r_gsel ? r_tm_ratio : r_sp_ratio);
                w_b = ALU_BW'(r_gsel ? r_r5 : r_r6);
            end
            S_GQ: begin
                w_ctl.op = OP_DIV;
                w_a      = ALU_AW'(r_num) << QS;
                w_b      = r_den;
            end
            default: begin
                w_ctl.op = OP_MUL;
            end
        endcase
    end

    psbb_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    logic [ROOT_W-1:0]  w_res_next;
    logic [GAMMA_W-1:0] w_gq;
    assign w_res_next = (w_res <= w_target) ? w_cand : r_res;
    assign w_gq       = (w_res[ALU_AW-1:GAMMA_W] != '0) ? GAMMA_SAT : w_res[GAMMA_W-1:0];

    // Sequencer, accumulators and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wait     <= 1'b0;
            r_valid    <= 1'b0;
            r_ax       <= '0;
            r_cells[0] <= CELLS_W'(16);
            r_cells[1] <= CELLS_W'(16);
            r_cells[2] <= CELLS_W'(16);
            r_bw_scale <= FIELD_W'(65536);
            r_sp_ratio <= FIELD_W'(65536);
            r_tm_ratio <= FIELD_W'(65536);
            r_cnt      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_min[i] <= COORD_TOP;
                r_max[i] <= COORD_BOT;
                r_sum[i] <= '0;
                r_sq[i]  <= '0;
            end
        end else begin
            r_valid <= 1'b0;

            // configuration write
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CELLS_X:  r_cells[0] <= i_cfg_data[CELLS_W-1:0];
                    CFG_CELLS_Y:  r_cells[1] <= i_cfg_data[CELLS_W-1:0];
                    CFG_CELLS_T:  r_cells[2] <= i_cfg_data[CELLS_W-1:0];
                    CFG_BW_SCALE: r_bw_scale <= i_cfg_data;
                    CFG_SP_RATIO: r_sp_ratio <= i_cfg_data;
                    CFG_TM_RATIO: r_tm_ratio <= i_cfg_data;
                    default: ;
                endcase
            end

            // launch the shared unit once per step
            if (w_ctl.go) r_wait <= 1'b1;

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_last <= i_last_point;
                        r_take <= r_cnt < CNT_W'(MAX_POINTS);
                        r_ax   <= '0;
                        for (int i = 0; i < 3; i++) r_pt[i] <= w_p[i];
                        if (r_cnt < CNT_W'(MAX_POINTS)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                            for (int i = 0; i < 3; i++) begin
                                if (w_p[i] < r_min[i]) r_min[i] <= w_p[i];
                                if (w_p[i] > r_max[i]) r_max[i] <= w_p[i];
                                r_sum[i] <= r_sum[i] + SUM_W'(w_p[i]);
                            end
                        end
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_take) r_sq[r_ax] <= r_sq[r_ax] + SQ_W'(unsigned'(w_sq));
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_zero  <= 1'b0;
                        r_state <= r_last ? S_STEP : S_IDLE;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_STEP: begin
                    if (r_wait && w_done) begin
                        r_wait       <= 1'b0;
                        r_step[r_ax] <= w_res[FIELD_W-1:0];
                        if (r_ax == 2'd2) begin
                            r_ax <= '0;
                            if (r_cnt < CNT_W'(2)) begin
                                r_gs    <= '0;
                                r_gt    <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_NN;
                            end
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end
                end
                S_NN: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_nn    <= w_res[ALU_BW-1:0];
                        r_state <= S_VA;
                    end
                end
                S_VA: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_ta    <= w_res;
                        r_state <= S_VB;
                    end
                end
                S_VB: begin
                    if (r_wait && w_done) begin
                        r_wait <= 1'b0;
                        if (r_ta <= w_res) begin
                            // no spread on this axis
                            r_var[r_ax] <= '0;
                            if (r_ax == 2'd2) begin
                                r_ax    <= '0;
                                r_state <= S_SQS;
                            end else begin
                                r_ax    <= r_ax + 2'd1;
                                r_state <= S_VA;
                            end
                        end else begin
                            r_ta    <= r_ta - w_res;
                            r_state <= S_VD;
                        end
                    end
                end
                S_VD: begin
                    if (r_wait && w_done) begin
                        r_wait      <= 1'b0;
                        r_var[r_ax] <= w_res[ALU_BW-1:0];
                        if (r_ax == 2'd2) begin
                            r_ax    <= '0;
                            r_state <= S_SQS;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_VA;
                        end
                    end
                end
                S_SQS: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_sds   <= w_res[GAMMA_W-1:0];
                        r_state <= S_SQT;
                    end
                end
                S_SQT: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_sdt   <= w_res[GAMMA_W-1:0];
                        r_res   <= '0;
                        r_bit   <= 5'(ROOT_W - 1);
                        r_rsel  <= 1'b0;
                        r_state <= S_RC2;
                    end
                end
                S_RC2: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_c2    <= w_res[ALU_BW-1:0];
                        r_state <= S_RC3;
                    end
                end
                S_RC3: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_c3    <= w_res[ALU_BW-1:0];
                        r_state <= S_RP;
                    end
                end
                S_RP: begin
                    // keep the trial bit when the candidate power stays in range
                    if (r_wait && w_done) begin
                        r_wait <= 1'b0;
                        if (r_bit == '0) begin
                            if (!r_rsel) begin
                                r_r6    <= w_res_next;
                                r_rsel  <= 1'b1;
                                r_res   <= '0;
                                r_bit   <= 5'(ROOT_W - 1);
                                r_state <= S_RC2;
                            end else begin
                                r_r5    <= w_res_next;
                                r_gsel  <= 1'b0;
                                r_state <= S_GD;
                            end
                        end else begin
                            r_res   <= w_res_next;
                            r_bit   <= r_bit - 5'd1;
                            r_state <= S_RC2;
                        end
                    end
                end
                S_GD: begin
                    if (r_wait && w_done) begin
                        r_wait <= 1'b0;
                        if (w_res[ALU_BW-1:0] == '0) begin
                            // zero divisor saturates this gamma
                            r_zero <= 1'b1;
                            if (r_gsel) begin
                                r_gt    <= GAMMA_SAT;
                                r_state <= S_OUT;
                            end else begin
                                r_gs    <= GAMMA_SAT;
                                r_gsel  <= 1'b1;
                                r_state <= S_GD;
                            end
                        end else begin
                            r_den   <= w_res[ALU_BW-1:0];
                            r_state <= S_GN;
                        end
                    end
                end
                S_GN: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_num   <= w_res[ALU_BW-1:0];
                        r_state <= S_GQ;
                    end
                end
                S_GQ: begin
                    if (r_wait && w_done) begin
                        r_wait <= 1'b0;
                        if (r_gsel) begin
                            r_gt    <= w_gq;
                            r_state <= S_OUT;
                        end else begin
                            r_gs    <= w_gq;
                            r_gsel  <= 1'b1;
                            r_state <= S_GD;
                        end
                    end
                end
                S_OUT: begin
                    // present the result and start a fresh set
                    r_valid <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        r_o_lo[i]   <= r_min[i];
                        r_o_hi[i]   <= r_max[i];
                        r_o_step[i] <= r_step[i];
                        r_min[i]    <= COORD_TOP;
                        r_max[i]    <= COORD_BOT;
                        r_sum[i]    <= '0;
                        r_sq[i]     <= '0;
                    end
                    r_o_gs <= r_gs;
                    r_o_gt <= r_gt;
                    if (r_cnt < CNT_W'(2))  r_o_stat <= STAT_FEW;
                    else if (r_zero)        r_o_stat <= STAT_ZERO;
                    else                    r_o_stat <= STAT_OK;
                    r_cnt   <= '0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_valid;
    assign o_x_low       = r_o_lo[0];
    assign o_x_high      = r_o_hi[0];
    assign o_y_low       = r_o_lo[1];
    assign o_y_high      = r_o_hi[1];
    assign o_t_low       = r_o_lo[2];
    assign o_t_high      = r_o_hi[2];
    assign o_step_x      = r_o_step[0];
    assign o_step_y      = r_o_step[1];
    assign o_step_t      = r_o_step[2];
    assign o_gamma_space = r_o_gs;
    assign o_gamma_time  = r_o_gt;
    assign o_status      = r_o_stat;

endmodule

`default_nettype wire

>>> verif/psbb_checker.sv
// Checker for the point-set bounds and bandwidth block: watches the point,
// configuration and result channels, predicts each set summary and compares.
// Depends on psbb_pkg.
`timescale 1ns / 100ps

module psbb_checker
    import psbb_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic signed [FIELD_W-1:0] i_pos_x,
    input  logic signed [FIELD_W-1:0] i_pos_y,
    input  logic signed [FIELD_W-1:0] i_pos_t,
    input  logic                      i_last_point,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CIDX_W-1:0]         i_cfg_index,
    input  logic [FIELD_W-1:0]        i_cfg_data,
    input  logic                      i_valid,
    input  logic [FIELD_W-1:0]        i_x_low,
    input  logic [FIELD_W-1:0]        i_x_high,
    input  logic [FIELD_W-1:0]        i_y_low,
    input  logic [FIELD_W-1:0]        i_y_high,
    input  logic [FIELD_W-1:0]        i_t_low,
    input  logic [FIELD_W-1:0]        i_t_high,
    input  logic [FIELD_W-1:0]        i_step_x,
    input  logic [FIELD_W-1:0]        i_step_y,
    input  logic [FIELD_W-1:0]        i_step_t,
    input  logic [GAMMA_W-1:0]        i_gamma_space,
    input  logic [GAMMA_W-1:0]        i_gamma_time,
    input  logic [STAT_W-1:0]         i_status,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct {
        logic [FIELD_W-1:0] lo[3];
        logic [FIELD_W-1:0] hi[3];
        logic [FIELD_W-1:0] step[3];
        logic [GAMMA_W-1:0] g_space;
        logic [GAMMA_W-1:0] g_time;
        logic [STAT_W-1:0]  status;
    } set_summary_t;

    localparam longint COORD_TOP = 64'sd8388607;

    set_summary_t expected_summaries[$];

    // Mirrored registers and running set statistics
    logic [CELLS_W-1:0] cells[3];
    logic [FIELD_W-1:0] bw_scale, sp_ratio, tm_ratio;
    longint      n_points;
    longint      lo_c[3], hi_c[3], sum_c[3];
    logic [63:0] sum_sq[3];

    function automatic logic [63:0] sample_var(longint s, logic [63:0] q, logic [63:0] n);
        logic [127:0] a, b;
        logic [63:0]  m;
        m = s < 0 ? 64'(-s) : 64'(s);
        a = 128'(n) * 128'(q);
        b = 128'(m) * 128'(m);
        if (a <= b) return 64'd0;
        return 64'((a - b) / 128'(n * (n - 1)));
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r, c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= 128'(v)) r = c;
        end
        return r;
    endfunction

    // floor(n^(1/k) * 2^16) by bitwise search
    function automatic logic [63:0] root_q16(logic [63:0] n, int k);
        logic [127:0] target, p;
        logic [63:0]  r, c;
        r = 0;
        target = 128'(n) << (16 * k);
        for (int b = 19; b >= 0; b--) begin
            c = r | (64'd1 << b);
            p = 1;
            for (int j = 0; j < k; j++) p = p * 128'(c);
            if (p <= target) r = c;
        end
        return r;
    endfunction

    function automatic logic [GAMMA_W-1:0] gamma_q16(logic [63:0] ratio, logic [63:0] root,
                                                     logic [63:0] den, output bit den_zero);
        logic [127:0] g;
        den_zero = (den == 0);
        if (den_zero) return '1;
        g = ((128'(ratio) * 128'(root)) << 16) / 128'(den);
        if (g > 128'hFFFF_FFFF) return '1;
        return g[GAMMA_W-1:0];
    endfunction

    function automatic set_summary_t close_set();
        set_summary_t e;
        logic [63:0]  v[3], den;
        bit           z_s, z_t;
        longint       range;
        for (int a = 0; a < 3; a++) begin
            e.lo[a] = lo_c[a][FIELD_W-1:0];
            e.hi[a] = hi_c[a][FIELD_W-1:0];
            range = hi_c[a] >= lo_c[a] ? hi_c[a] - lo_c[a] : 0;
            e.step[a] = FIELD_W'(64'(range) / (cells[a] == 0 ? 64'd1 : 64'(cells[a])));
        end
        if (n_points < 2) begin
            e.g_space = 0;
            e.g_time  = 0;
            e.status  = STAT_FEW;
        end else begin
            for (int a = 0; a < 3; a++) v[a] = sample_var(sum_c[a], sum_sq[a], n_points);
            den = 64'(bw_scale) * floor_sqrt((v[0] + v[1]) << 16);
            e.g_space = gamma_q16(sp_ratio, root_q16(n_points, 6), den, z_s);
            den = 64'(bw_scale) * floor_sqrt(v[2] << 16);
            e.g_time = gamma_q16(tm_ratio, root_q16(n_points, 5), den, z_t);
            e.status = (z_s || z_t) ? STAT_ZERO : STAT_OK;
        end
        return e;
    endfunction

    function automatic void clear_set();
        n_points = 0;
        for (int a = 0; a < 3; a++) begin
            lo_c[a]   = COORD_TOP;
            hi_c[a]   = -COORD_TOP - 1;
            sum_c[a]  = 0;
            sum_sq[a] = 0;
        end
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_summaries.size();

    always @(posedge i_clk) begin
        longint p[3];
        set_summary_t e;
        if (!i_rst_n) begin
            foreach (cells[a]) cells[a] = 16;
            bw_scale = 65536;
            sp_ratio = 65536;
            tm_ratio = 65536;
            clear_set();
            expected_summaries.delete();
        end else begin
            // register write transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CELLS_X:  cells[0] = i_cfg_data[CELLS_W-1:0];
                    CFG_CELLS_Y:  cells[1] = i_cfg_data[CELLS_W-1:0];
                    CFG_CELLS_T:  cells[2] = i_cfg_data[CELLS_W-1:0];
                    CFG_BW_SCALE: bw_scale = i_cfg_data;
                    CFG_SP_RATIO: sp_ratio = i_cfg_data;
                    CFG_TM_RATIO: tm_ratio = i_cfg_data;
                    default: ;
                endcase
            end
            // point transfer
            if (i_start && !i_busy) begin
                p[0] = i_pos_x;
                p[1] = i_pos_y;
                p[2] = i_pos_t;
                if (n_points < MAX_POINTS) begin
                    n_points++;
                    for (int a = 0; a < 3; a++) begin
                        if (p[a] < lo_c[a]) lo_c[a] = p[a];
                        if (p[a] > hi_c[a]) hi_c[a] = p[a];
                        sum_c[a]  += p[a];
                        sum_sq[a] += 64'(p[a] * p[a]);
                    end
                end
                if (i_last_point) begin
                    expected_summaries.push_back(close_set());
                    clear_set();
                end
            end
            // result transfer
            if (i_valid) begin
                if (expected_summaries.size() == 0) begin
                    $error("result with no set pending");
                    o_fail_count++;
                end else begin
                    e = expected_summaries.pop_front();
                    check_field("x_low",       e.lo[0],   i_x_low);
                    check_field("x_high",      e.hi[0],   i_x_high);
                    check_field("y_low",       e.lo[1],   i_y_low);
                    check_field("y_high",      e.hi[1],   i_y_high);
                    check_field("t_low",       e.lo[2],   i_t_low);
                    check_field("t_high",      e.hi[2],   i_t_high);
                    check_field("step_x",      e.step[0], i_step_x);
                    check_field("step_y",      e.step[1], i_step_y);
                    check_field("step_t",      e.step[2], i_step_t);
                    check_field("gamma_space", e.g_space, i_gamma_space);
                    check_field("gamma_time",  e.g_time,  i_gamma_time);
                    check_field("status",      e.status,  i_status);
                end
            end
        end
    end

endmodule

>>> verif/point_set_bounds_and_bandwidth_tb.sv
// Testbench top for point_set_bounds_and_bandwidth: drives point sets and
// register settings, and gives the verdict. Depends on psbb_pkg, psbb_checker.
`timescale 1ns / 100ps

module point_set_bounds_and_bandwidth_tb;
    import psbb_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int NUM_PHASES      = 8;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic signed [FIELD_W-1:0] i_pos_x = 0, i_pos_y = 0, i_pos_t = 0;
    logic i_last_point = 0;
    logic i_cfg_valid = 0;
    logic [CIDX_W-1:0]  i_cfg_index = CFG_CELLS_X;
    logic [FIELD_W-1:0] i_cfg_data = 0;
    logic o_busy, o_cfg_ready, o_valid;
    logic [FIELD_W-1:0] o_x_low, o_x_high, o_y_low, o_y_high, o_t_low, o_t_high;
    logic [FIELD_W-1:0] o_step_x, o_step_y, o_step_t;
    logic [GAMMA_W-1:0] o_gamma_space, o_gamma_time;
    logic [STAT_W-1:0]  o_status;
    int fail_count, sets_pending, quiet_cycles;
    bit no_gaps;

    point_set_bounds_and_bandwidth uut (.*);

    psbb_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_pos_x, .i_pos_y, .i_pos_t,
        .i_last_point, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_valid(o_valid), .i_x_low(o_x_low), .i_x_high(o_x_high), .i_y_low(o_y_low),
        .i_y_high(o_y_high), .i_t_low(o_t_low), .i_t_high(o_t_high), .i_step_x(o_step_x),
        .i_step_y(o_step_y), .i_step_t(o_step_t), .i_gamma_space(o_gamma_space),
        .i_gamma_time(o_gamma_time), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(sets_pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_valid || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                              logic [FIELD_W-1:0] t, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_pos_t      <= t;
        i_last_point <= last;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    // Block done with every set: nothing pending, then settle and confirm not busy
    task automatic drain();
        i_start <= 0;
        while (sets_pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Coordinate per set style: full range, clustered, constant, or one-bit flip
    function automatic logic [FIELD_W-1:0] draw_coord(int style, logic [FIELD_W-1:0] base);
        case (style)
            0: return FIELD_W'($urandom);
            1: return base + FIELD_W'($urandom_range(0, 4095)) - FIELD_W'(2048);
            2: return base;
            default: return base ^ FIELD_W'(1 << $urandom_range(0, FIELD_W - 1));
        endcase
    endfunction

    task automatic random_set();
        int len, style[3];
        logic [FIELD_W-1:0] base[3], c[3];
        len = ($urandom_range(0, 9) == 0) ? 1 :
              ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 8);
        foreach (style[a]) begin
            style[a] = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 3);
            base[a]  = FIELD_W'($urandom);
        end
        for (int i = 0; i < len; i++) begin
            foreach (c[a]) c[a] = draw_coord(style[a], base[a]);
            send_point(c[0], c[1], c[2], i == len - 1);
        end
    endtask

    initial begin
        logic [FIELD_W-1:0] mx, mn;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        no_gaps = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: single point, extreme spans, zero spread, one flat axis
        send_point(mx, mn, mx, 1);
        send_point(mn, mn, mn, 0);
        send_point(mx, mx, mx, 1);
        send_point(mn, mx, 0, 0);
        send_point(mx, mn, 24'hFFFFFF, 1);
        repeat (3) send_point(24'h001234, 24'h001234, 24'h000100, 0);
        send_point(24'h001234, 24'h001234, 24'h000100, 1);
        send_point(24'h000100, 24'hFFFF00, 24'h000500, 0);
        send_point(24'h555555, 24'hAAAAAA, 24'h000500, 0);
        send_point(24'h000001, 24'h000002, 24'h000500, 1);
        drain();

        // Register settings per phase, extremes first, then random
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            no_gaps = (ph % 3 == 1);
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_CELLS_X, 0);
                    write_reg(CFG_CELLS_Y, 0);
                    write_reg(CFG_CELLS_T, 0);
                    write_reg(CFG_BW_SCALE, 0);
                    write_reg(CFG_SP_RATIO, '1);
                    write_reg(CFG_TM_RATIO, '1);
                end
                2: begin
                    write_reg(CFG_CELLS_X, 4096);
                    write_reg(CFG_CELLS_Y, 1);
                    write_reg(CFG_CELLS_T, '1);
                    write_reg(CFG_BW_SCALE, 1);
                    write_reg(CFG_SP_RATIO, '1);
                    write_reg(CFG_TM_RATIO, 0);
                end
                3: begin
                    write_reg(CFG_CELLS_X, 1);
                    write_reg(CFG_CELLS_Y, 4096);
                    write_reg(CFG_CELLS_T, 1);
                    write_reg(CFG_BW_SCALE, '1);
                    write_reg(CFG_SP_RATIO, 0);
                    write_reg(CFG_TM_RATIO, 1);
                end
                default: begin
                    write_reg(CFG_CELLS_X, FIELD_W'($urandom));
                    write_reg(CFG_CELLS_Y, FIELD_W'($urandom_range(1, 4096)));
                    write_reg(CFG_CELLS_T, FIELD_W'($urandom_range(1, 64)));
                    write_reg(CFG_BW_SCALE, FIELD_W'($urandom));
                    write_reg(CFG_SP_RATIO, FIELD_W'($urandom));
                    write_reg(CFG_TM_RATIO, FIELD_W'($urandom_range(0, 131072)));
                end
            endcase
            repeat (32) random_set();
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && sets_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
